/* rtl/spqa_pkg.sv */
// Shared constants and types for the sorted priority queue with aging.
package spqa_pkg;

   localparam int SPQA_DEPTH = 16;

   localparam logic [15:0] AGE_LIMIT_RESET = 16'd100;
   localparam logic [15:0] AGE_MAX         = 16'hFFFF;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_REPORT = 3'b100
   } spqa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_item;
      logic exec_item;
      logic load_rsp;
   } spqa_cmd_type;

endpackage

/* rtl/spqa_ctrl.sv */
// Controller state machine: accept one transfer, execute it, present the result.
module spqa_ctrl
   import spqa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output spqa_cmd_type cmd
);

   spqa_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd.latch_item = 1'b0;
      cmd.exec_item  = 1'b0;
      cmd.load_rsp   = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec_item = 1'b1;
            state_in      = ST_REPORT;
         end
         ST_REPORT: begin
            // Wait until the output register is free, then load it.
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/spqa_datapath.sv */
// Datapath: row of queue cells with parallel compare, shift and aging, plus result register.
module spqa_datapath
   import spqa_pkg::*;
#(
   parameter int DEPTH = SPQA_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  spqa_cmd_type cmd,
   input  logic         req_opcode,
   input  logic [15:0]  req_job_id,
   input  logic [7:0]   req_job_priority,
   input  logic [11:0]  req_job_size,
   input  logic         csr_write,
   input  logic [15:0]  csr_age_limit,
   output logic [4:0]   rsp_queue_count,
   output logic         rsp_head_valid,
   output logic [15:0]  rsp_head_id,
   output logic [7:0]   rsp_head_priority,
   output logic [11:0]  rsp_head_size,
   output logic [15:0]  rsp_head_age,
   output logic         rsp_dropped,
   output logic         rsp_limit_reached
);

   localparam int CW = $clog2(DEPTH + 1);

   // Latched item
   logic        op_ff;
   logic [15:0] id_ff;
   logic [7:0]  pri_ff;
   logic [11:0] size_ff;

   logic [15:0] age_limit_ff;

   // Cells
   logic        valid_ff [DEPTH];
   logic        valid_in [DEPTH];
   logic [15:0] cid_ff   [DEPTH];
   logic [15:0] cid_in   [DEPTH];
   logic [7:0]  cpri_ff  [DEPTH];
   logic [7:0]  cpri_in  [DEPTH];
   logic [11:0] csize_ff [DEPTH];
   logic [11:0] csize_in [DEPTH];
   logic [15:0] cage_ff  [DEPTH];
   logic [15:0] cage_in  [DEPTH];
   logic        hit      [DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic          full;
   logic          dropped_ff, dropped_in;
   logic          reached_ff, reached_in;
   logic [31:0]   count_wide;

   assign full = (count_ff == CW'(DEPTH));

   always_comb begin
      reached_in = 1'b0;
      dropped_in = 1'b0;
      count_in   = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         valid_in[i] = valid_ff[i];
         cid_in[i]   = cid_ff[i];
         cpri_in[i]  = cpri_ff[i];
         csize_in[i] = csize_ff[i];
         cage_in[i]  = cage_ff[i];
         // Cell takes the new job or shifts: empty, or its key is not below the new one.
         hit[i] = !valid_ff[i] || (cpri_ff[i] > pri_ff) ||
                  ((cpri_ff[i] == pri_ff) && (csize_ff[i] >= size_ff));
      end
      if (cmd.exec_item) begin
         if (op_ff == OP_INSERT) begin
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (i > 0 && hit[(i > 0) ? i - 1 : 0]) begin
                     cid_in[i]   = cid_ff[(i > 0) ? i - 1 : 0];
                     cpri_in[i]  = cpri_ff[(i > 0) ? i - 1 : 0];
                     csize_in[i] = csize_ff[(i > 0) ? i - 1 : 0];
                     cage_in[i]  = cage_ff[(i > 0) ? i - 1 : 0];
                  end else if (hit[i]) begin
                     cid_in[i]   = id_ff;
                     cpri_in[i]  = pri_ff;
                     csize_in[i] = size_ff;
                     cage_in[i]  = '0;
                  end
                  valid_in[i] = valid_ff[i] || (i == 0) || valid_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (valid_ff[i] && (cage_ff[i] != AGE_MAX)) begin
                  cage_in[i] = cage_ff[i] + 16'd1;
                  if (cage_in[i] == age_limit_ff) begin
                     reached_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         op_ff   <= req_opcode;
         id_ff   <= req_job_id;
         pri_ff  <= req_job_priority;
         size_ff <= req_job_size;
      end
      if (cmd.exec_item) begin
         dropped_ff <= dropped_in;
         reached_ff <= reached_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         cid_ff[i]   <= cid_in[i];
         cpri_ff[i]  <= cpri_in[i];
         csize_ff[i] <= csize_in[i];
         cage_ff[i]  <= cage_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         age_limit_ff <= AGE_LIMIT_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         count_ff <= count_in;
         if (csr_write) begin
            age_limit_ff <= csr_age_limit;
         end
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign count_wide = 32'(count_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_queue_count   <= count_wide[4:0];
         rsp_head_valid    <= valid_ff[0];
         rsp_head_id       <= valid_ff[0] ? cid_ff[0]   : '0;
         rsp_head_priority <= valid_ff[0] ? cpri_ff[0]  : '0;
         rsp_head_size     <= valid_ff[0] ? csize_ff[0] : '0;
         rsp_head_age      <= valid_ff[0] ? cage_ff[0]  : '0;
         rsp_dropped       <= dropped_ff;
         rsp_limit_reached <= reached_ff;
      end
   end

endmodule

/* rtl/sorted_priority_queue_with_aging_core.sv */
// Top level of the sorted priority queue with aging.
// Holds up to DEPTH jobs sorted by priority number, then size; the head is the
// lowest priority number with the smallest size. Each request transfer is either
// an insert (opcode 0) or a tick (opcode 1) that ages every entry by one,
// saturating at 65535; every request yields exactly one response transfer with
// the count and head entry after the operation. An insert into a full queue is
// dropped and flagged; a tick flags when any age becomes equal to age_limit.
// Each request is accepted, then executed, with every cell comparing its entry
// with the new job in parallel and shifting or aging, and then the response
// register is loaded. A new request is accepted only once the previous one has
// been loaded into the response register; that register frees the block while
// a result waits. age_limit is written through the csr channel (always ready)
// and should be written only while the block is idle; reset value is 100.
module sorted_priority_queue_with_aging_core
   import spqa_pkg::*;
#(
   parameter int DEPTH = SPQA_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_job_id,
   input  logic [7:0]  req_job_priority,
   input  logic [11:0] req_job_size,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_queue_count,
   output logic        rsp_head_valid,
   output logic [15:0] rsp_head_id,
   output logic [7:0]  rsp_head_priority,
   output logic [11:0] rsp_head_size,
   output logic [15:0] rsp_head_age,
   output logic        rsp_dropped,
   output logic        rsp_limit_reached,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_age_limit
);

   spqa_cmd_type cmd;

   // The register accepts a write every cycle.
   assign csr_ready = 1'b1;

   spqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   spqa_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_job_id        (req_job_id),
      .req_job_priority  (req_job_priority),
      .req_job_size      (req_job_size),
      .csr_write         (csr_valid && csr_ready),
      .csr_age_limit     (csr_age_limit),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_id       (rsp_head_id),
      .rsp_head_priority (rsp_head_priority),
      .rsp_head_size     (rsp_head_size),
      .rsp_head_age      (rsp_head_age),
      .rsp_dropped       (rsp_dropped),
      .rsp_limit_reached (rsp_limit_reached)
   );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the sorted priority queue with aging.
`timescale 1ns / 1ps

module testbench;
   import spqa_pkg::*;

   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int TICK_RUN        = 40;

   typedef struct {
      logic        opcode;
      logic [15:0] job_id;
      logic [7:0]  job_prio;
      logic [11:0] job_size;
   } job_request_type;

   typedef struct {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [11:0] size;
      logic [15:0] age;
   } job_entry_type;

   typedef struct {
      logic [4:0]  queue_count;
      logic        head_valid;
      logic [15:0] head_id;
      logic [7:0]  head_prio;
      logic [11:0] head_size;
      logic [15:0] head_age;
      logic        dropped;
      logic        limit_reached;
   } queue_status_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_opcode       = OP_INSERT;
   logic [15:0] req_job_id       = '0;
   logic [7:0]  req_job_priority = '0;
   logic [11:0] req_job_size     = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [4:0]  rsp_queue_count;
   logic        rsp_head_valid;
   logic [15:0] rsp_head_id;
   logic [7:0]  rsp_head_priority;
   logic [11:0] rsp_head_size;
   logic [15:0] rsp_head_age;
   logic        rsp_dropped;
   logic        rsp_limit_reached;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_age_limit    = AGE_LIMIT_RESET;

   // Shadow of the queue contents and the age limit register.
   job_entry_type    shadow_jobs [SPQA_DEPTH];
   int               shadow_count     = 0;
   logic [15:0]      shadow_age_limit = AGE_LIMIT_RESET;
   queue_status_type expected_status [$];

   int mismatch_count  = 0;
   int cycle_count     = 0;
   int tx_gap_pct      = 0;
   int rx_stall_pct    = 0;
   int rsp_hold_cycles = 0;

   sorted_priority_queue_with_aging_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_job_id        (req_job_id),
      .req_job_priority  (req_job_priority),
      .req_job_size      (req_job_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_id       (rsp_head_id),
      .rsp_head_priority (rsp_head_priority),
      .rsp_head_size     (rsp_head_size),
      .rsp_head_age      (rsp_head_age),
      .rsp_dropped       (rsp_dropped),
      .rsp_limit_reached (rsp_limit_reached),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_age_limit     (csr_age_limit)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Apply one request to the shadow queue and return the status it leaves behind.
   function automatic queue_status_type advance_queue(job_request_type req);
      queue_status_type st;
      int               pos;
      st = '{default: '0};
      if (req.opcode == OP_INSERT) begin
         if (shadow_count >= SPQA_DEPTH) begin
            st.dropped = 1'b1;
         end else begin
            // Scan from the tail so the first qualifying slot wins.
            pos = shadow_count;
            for (int i = shadow_count - 1; i >= 0; i--) begin
               if (shadow_jobs[i].prio > req.job_prio ||
                   (shadow_jobs[i].prio == req.job_prio &&
                    shadow_jobs[i].size >= req.job_size))
                  pos = i;
            end
            for (int i = shadow_count; i > pos; i--)
               shadow_jobs[i] = shadow_jobs[i - 1];
            shadow_jobs[pos] = '{id: req.job_id, prio: req.job_prio,
                                 size: req.job_size, age: '0};
            shadow_count++;
         end
      end else begin
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_jobs[i].age != AGE_MAX) begin
               shadow_jobs[i].age = shadow_jobs[i].age + 16'd1;
               if (shadow_jobs[i].age == shadow_age_limit)
                  st.limit_reached = 1'b1;
            end
         end
      end
      st.queue_count = shadow_count[4:0];
      if (shadow_count > 0) begin
         st.head_valid = 1'b1;
         st.head_id    = shadow_jobs[0].id;
         st.head_prio  = shadow_jobs[0].prio;
         st.head_size  = shadow_jobs[0].size;
         st.head_age   = shadow_jobs[0].age;
      end
      return st;
   endfunction

   function automatic job_request_type make_insert(logic [15:0] id, logic [7:0] prio,
                                                   logic [11:0] size);
      job_request_type req;
      req = '{opcode: OP_INSERT, job_id: id, job_prio: prio, job_size: size};
      return req;
   endfunction

   function automatic job_request_type make_tick();
      job_request_type req;
      req = '{opcode: OP_TICK, job_id: 16'($urandom), job_prio: 8'($urandom),
              job_size: 12'($urandom)};
      return req;
   endfunction

   // Random job; half the time squeeze priority and size to force ties.
   function automatic job_request_type random_request();
      job_request_type req;
      req.opcode = $urandom_range(0, 1) ? OP_TICK : OP_INSERT;
      req.job_id = 16'($urandom);
      if ($urandom_range(0, 1)) begin
         req.job_prio = 8'($urandom_range(0, 3));
         req.job_size = 12'($urandom_range(0, 3));
      end else begin
         req.job_prio = 8'($urandom);
         req.job_size = 12'($urandom);
      end
      return req;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got 0x%0h want 0x%0h at cycle %0d",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   task automatic check_field(string what, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   // Offer one request, hold it until the transfer, then predict its result.
   task automatic send_request(job_request_type req);
      int gap;
      req_valid        <= 1'b1;
      req_opcode       <= req.opcode;
      req_job_id       <= req.job_id;
      req_job_priority <= req.job_prio;
      req_job_size     <= req.job_size;
      do @(posedge clock); while (req_stall);
      expected_status.push_back(advance_queue(req));
      gap = pick_gap(tx_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding result.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_age_limit(logic [15:0] limit);
      drain_results();
      // Let the controller settle before touching the register.
      repeat (4) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_age_limit <= limit;
      do @(posedge clock); while (!csr_ready);
      shadow_age_limit = limit;
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_queue();
      send_request(make_tick());
   endtask

   task automatic test_insert_order();
      tx_gap_pct   = 30;
      rx_stall_pct = 30;
      send_request(make_insert(16'hFFFF, 8'd255, 12'hFFF));
      send_request(make_insert(16'h0000, 8'd0, 12'h000));
      // equal priority and size: the newcomer goes ahead
      send_request(make_insert(16'h0001, 8'd0, 12'h000));
      // equal priority, larger size: lands behind both
      send_request(make_insert(16'h0002, 8'd0, 12'h001));
      send_request(make_tick());
      send_request(make_insert(16'h8000, 8'd128, 12'h800));
      send_request(make_insert(16'h7FFF, 8'd128, 12'h7FF));
      send_request(make_insert(16'h5555, 8'd255, 12'hFFF));
      send_request(make_tick());
   endtask

   task automatic test_age_limits();
      write_age_limit(16'd1);
      send_request(make_insert(16'hAAAA, 8'd64, 12'h555));
      send_request(make_tick());
      // a limit of zero is never matched by an incremented age
      write_age_limit(16'd0);
      send_request(make_tick());
      write_age_limit(16'd4);
      send_request(make_tick());
      send_request(make_tick());
      write_age_limit(AGE_MAX);
   endtask

   // Run ticks back to back; the late insert trails the first one in age.
   task automatic test_tick_run();
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      send_request(make_insert(16'h1234, 8'd32, 12'h100));
      repeat (20) send_request(make_tick());
      send_request(make_insert(16'h4321, 8'd32, 12'h100));
      repeat (TICK_RUN) send_request(make_tick());
   endtask

   task automatic test_backpressure();
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      write_age_limit(16'd3);
      // Hold the response side while requests keep coming.
      rsp_hold_cycles = 150;
      repeat (20) send_request(random_request());
      drain_results();
      repeat (20) send_request(random_request());
   endtask

   task automatic test_random_traffic();
      logic [15:0] limit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       limit = 16'd1;
            1:       limit = 16'($urandom_range(2, 40));
            2:       limit = 16'd0;
            3:       limit = AGE_MAX;
            default: limit = 16'($urandom);
         endcase
         write_age_limit(limit);
         tx_gap_pct   = (phase % 3) * 30;
         rx_stall_pct = ((phase + 1) % 3) * 30;
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
   endtask

   // Response side: random stalls, or a long hold when one is requested.
   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = pick_gap(rx_stall_pct);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin : check_results
      queue_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected transfer, queue_count", 32'(rsp_queue_count), 0);
         end else begin
            want = expected_status.pop_front();
            check_field("queue_count", 32'(rsp_queue_count), 32'(want.queue_count));
            check_field("head_valid", 32'(rsp_head_valid), 32'(want.head_valid));
            check_field("head_id", 32'(rsp_head_id), 32'(want.head_id));
            check_field("head_priority", 32'(rsp_head_priority), 32'(want.head_prio));
            check_field("head_size", 32'(rsp_head_size), 32'(want.head_size));
            check_field("head_age", 32'(rsp_head_age), 32'(want.head_age));
            check_field("dropped", 32'(rsp_dropped), 32'(want.dropped));
            check_field("limit_reached", 32'(rsp_limit_reached),
                        32'(want.limit_reached));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL sorted_priority_queue_with_aging_core");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_insert_order();
      test_age_limits();
      test_tick_run();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS sorted_priority_queue_with_aging_core");
      else
         $display("FAIL sorted_priority_queue_with_aging_core");
      $finish;
   end

endmodule

/* files.f */
rtl/spqa_pkg.sv
rtl/spqa_ctrl.sv
rtl/spqa_datapath.sv
rtl/sorted_priority_queue_with_aging_core.sv
bench/testbench.sv
